### src/pati_pkg.sv
// Shared types and constants for the positive-area trapezoid integrator.
// Used by the shared multiply/divide unit and by the top-level sequencer.
// No dependencies.
package pati_pkg;

  // Shift-add multiply runs over the 33-bit operand, restoring divide over a 66-bit dividend
  localparam int unsigned MagW     = 33;
  localparam int unsigned QuotW    = 66;
  localparam int unsigned MulSteps = MagW;
  localparam int unsigned DivSteps = QuotW;
  localparam int unsigned CntW     = $clog2(DivSteps + 1);
  localparam int unsigned ProdW    = 64 + MagW;
  localparam int unsigned FracW    = 16;
  localparam int unsigned TermW    = ProdW - FracW;

  typedef enum logic {
    MduMul,
    MduDiv
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
  } mdu_req_t;

  typedef enum logic [1:0] {
    CfgStartX     = 2'd0,
    CfgUpperLimit = 2'd1,
    CfgScale      = 2'd2
  } cfg_idx_e;

endpackage

### src/pati_mdu.sv
// Iterative multiply/divide unit: radix-2 shift-add multiply and restoring divide.
// One 65-bit adder serves both operations. Depends on pati_pkg.
module pati_mdu import pati_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mdu_req_t         req_i,
  input  logic [QuotW-1:0] opa_i,
  input  logic [MagW-1:0]  opb_i,
  output logic             done_o,
  output logic [ProdW-1:0] res_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  mdu_op_e          op_q, op_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ProdW-1:0] p_q, p_d;
  logic [MagW-1:0]  r_q, r_d;
  logic [63:0]      a_q, a_d;
  logic [MagW-1:0]  d_q, d_d;

  logic [MagW:0]    trial;
  logic [63:0]      add_a, add_b;
  logic             add_cin;
  logic [64:0]      sum;

  // Next partial remainder candidate: shift in the next dividend bit
  assign trial = {r_q, p_q[QuotW-1]};

  // Shared adder: accumulate for multiply, trial subtract for divide
  always_comb begin
    if (op_q == MduMul) begin
      add_a   = p_q[ProdW-1:MagW];
      add_b   = p_q[0] ? a_q : 64'd0;
      add_cin = 1'b0;
    end else begin
      add_a   = {{(64 - MagW - 1){1'b0}}, trial};
      add_b   = ~{{(64 - MagW){1'b0}}, d_q};
      add_cin = 1'b1;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {64'd0, add_cin};
  end

  // Load operands on a request, then step once per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    p_d    = p_q;
    r_d    = r_q;
    a_d    = a_q;
    d_d    = d_q;
    if (req_i.start) begin
      op_d   = req_i.op;
      busy_d = 1'b1;
      if (req_i.op == MduMul) begin
        a_d   = opa_i[63:0];
        p_d   = {64'd0, opb_i};
        cnt_d = CntW'(MulSteps);
      end else begin
        p_d   = {{(ProdW - QuotW){1'b0}}, opa_i};
        r_d   = '0;
        d_d   = opb_i;
        cnt_d = CntW'(DivSteps);
      end
    end else if (busy_q) begin
      case (op_q)
        MduMul: begin
          p_d = {sum, p_q[MagW-1:1]};
        end
        MduDiv: begin
          r_d = sum[64] ? sum[MagW-1:0] : trial[MagW-1:0];
          p_d = {p_q[ProdW-2:0], sum[64]};
        end
        default: ;
      endcase
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= MduMul;
      cnt_q  <= '0;
      p_q    <= '0;
      r_q    <= '0;
      a_q    <= '0;
      d_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
      p_q    <= p_d;
      r_q    <= r_d;
      a_q    <= a_d;
      d_q    <= d_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = p_q;

endmodule

### src/positive_area_trapezoid_integrator_core.sv
// Work per accepted word: none when it adds nothing, one 33-step multiply for a plain
// segment, and for a zero-crossing or limit segment a multiply, a 66-step divide and a multiply,
// all in the one shared unit. End of sweep adds the scale multiply before the result word
// shows; it shows later while the result register is stalled.
// Reset (async, active low) clears the sweep state and sets start_x 0, upper_limit 0,
// scale 1.0; the result register is empty after reset.
module positive_area_trapezoid_integrator_core import pati_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] x_sample_i,
  input  logic signed [31:0] y_sample_i,
  input  logic               end_of_sweep_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] area_o,
  output logic               start_found_o
);

  typedef enum logic [3:0] {
    StIdle, StDecide, StMul1, StDiv, StPost, StMul2, StAcc, StFinal, StScale, StEmit
  } state_e;

  typedef enum logic [1:0] {
    SegPlain, SegCross, SegLimit
  } seg_e;

  // Signed value of a magnitude, saturated to 64 bits
  function automatic logic signed [63:0] sat_mag(input logic neg, input logic [TermW-1:0] mag);
    logic [TermW-1:0] lim;
    logic [63:0]      m64;
    lim = neg ? (TermW'(1) << 63) : ((TermW'(1) << 63) - TermW'(1));
    m64 = mag[63:0];
    if (mag > lim) begin
      sat_mag = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_mag = neg ? signed'(-m64) : signed'(m64);
    end
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = signed'(s[63:0]);
    end
  endfunction

  function automatic logic [32:0] mag33(input logic [32:0] v);
    mag33 = v[32] ? -v : v;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? -v : v;
  endfunction

  state_e             state_q, state_d;
  seg_e               seg_q, seg_d;
  logic signed [31:0] start_x_q, start_x_d;
  logic signed [31:0] upper_q, upper_d;
  logic [31:0]        scale_q, scale_d;
  logic               armed_q, armed_d;
  logic               limit_q, limit_d;
  logic signed [31:0] px_q, px_d;
  logic signed [31:0] py_q, py_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [31:0] x_q, x_d;
  logic signed [31:0] y_q, y_d;
  logic               eos_q, eos_d;
  logic               neg1_q, neg1_d;
  logic               neg2_q, neg2_d;
  logic signed [63:0] r_q, r_d;
  logic signed [63:0] term_q, term_d;
  mdu_req_t           req_q, req_d;
  logic [QuotW-1:0]   opa_q, opa_d;
  logic [MagW-1:0]    opb_q, opb_d;
  logic               out_valid_q, out_valid_d;
  logic signed [63:0] area_q, area_d;
  logic               found_q, found_d;

  logic               mdu_done;
  logic [ProdW-1:0]   mdu_res;

  logic [32:0]        dx, du, dy, sy;
  logic signed [63:0] y0_dbl, s_lim;

  // Segment differences, all exact in 33 bits
  assign dx     = {x_q[31], x_q} - {px_q[31], px_q};
  assign du     = {upper_q[31], upper_q} - {px_q[31], px_q};
  assign dy     = {y_q[31], y_q} - {py_q[31], py_q};
  assign sy     = {y_q[31], y_q} + {py_q[31], py_q};
  assign y0_dbl = {{31{py_q[31]}}, py_q, 1'b0};
  assign s_lim  = sat_add(y0_dbl, r_q);

  pati_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .opa_i  (opa_q),
    .opb_i  (opb_q),
    .done_o (mdu_done),
    .res_o  (mdu_res)
  );

  always_comb begin
    state_d     = state_q;
    seg_d       = seg_q;
    start_x_d   = start_x_q;
    upper_d     = upper_q;
    scale_d     = scale_q;
    armed_d     = armed_q;
    limit_d     = limit_q;
    px_d        = px_q;
    py_d        = py_q;
    acc_d       = acc_q;
    x_d         = x_q;
    y_d         = y_q;
    eos_d       = eos_q;
    neg1_d      = neg1_q;
    neg2_d      = neg2_q;
    r_d         = r_q;
    term_d      = term_q;
    req_d.start = 1'b0;
    req_d.op    = req_q.op;
    opa_d       = opa_q;
    opb_d       = opb_q;
    out_valid_d = out_valid_q;
    area_d      = area_q;
    found_d     = found_q;

    // Configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartX:     start_x_d = signed'(cfg_data_i);
        CfgUpperLimit: upper_d   = signed'(cfg_data_i);
        CfgScale:      scale_d   = cfg_data_i;
        default: ;
      endcase
    end

    // Drop the result word once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          x_d     = x_sample_i;
          y_d     = y_sample_i;
          eos_d   = end_of_sweep_i;
          state_d = StDecide;
        end
      end

      // Arm on the start value, or pick the segment kind and start its first multiply when it adds area
      StDecide: begin
        state_d = StFinal;
        if (!armed_q) begin
          if (x_q == start_x_q) begin
            armed_d = 1'b1;
            px_d    = x_q;
            py_d    = y_q;
          end
        end else if (!limit_q) begin
          if (x_q >= upper_q) begin
            limit_d = 1'b1;
            if (dx == 33'd0) begin
              px_d = x_q;
              py_d = y_q;
            end else begin
              seg_d       = SegLimit;
              neg1_d      = dy[32] ^ du[32] ^ dx[32];
              opa_d       = {33'd0, mag33(dy)};
              opb_d       = mag33(du);
              req_d.start = 1'b1;
              req_d.op    = MduMul;
              state_d     = StMul1;
            end
          end else if (py_q <= 0 && y_q <= 0) begin
            px_d = x_q;
            py_d = y_q;
          end else if (py_q < 0 || y_q < 0) begin
            // Zero crossing: square the positive end
            seg_d       = SegCross;
            neg1_d      = 1'b0;
            opa_d       = (py_q < 0) ? {34'd0, y_q} : {34'd0, py_q};
            opb_d       = (py_q < 0) ? {1'b0, y_q} : {1'b0, py_q};
            req_d.start = 1'b1;
            req_d.op    = MduMul;
            state_d     = StMul1;
          end else begin
            seg_d       = SegPlain;
            neg2_d      = dx[32] ^ sy[32];
            opa_d       = {33'd0, mag33(sy)};
            opb_d       = mag33(dx);
            req_d.start = 1'b1;
            req_d.op    = MduMul;
            state_d     = StMul2;
          end
        end
      end

      // Divide the first product by |dx| (limit) or by the y span (crossing)
      StMul1: begin
        if (mdu_done) begin
          opa_d       = mdu_res[QuotW-1:0];
          opb_d       = (seg_q == SegLimit) ? mag33(dx) : mag33(dy);
          req_d.start = 1'b1;
          req_d.op    = MduDiv;
          state_d     = StDiv;
        end
      end

      StDiv: begin
        if (mdu_done) begin
          r_d     = sat_mag(neg1_q, {{(TermW - QuotW){1'b0}}, mdu_res[QuotW-1:0]});
          state_d = StPost;
        end
      end

      // Form the second multiply operands
      StPost: begin
        if (seg_q == SegLimit) begin
          opa_d  = {2'd0, mag64(s_lim)};
          opb_d  = mag33(du);
          neg2_d = s_lim[63] ^ du[32];
        end else begin
          opa_d  = {2'd0, r_q};
          opb_d  = mag33(dx);
          neg2_d = dx[32];
        end
        req_d.start = 1'b1;
        req_d.op    = MduMul;
        state_d     = StMul2;
      end

      StMul2: begin
        if (mdu_done) begin
          term_d  = sat_mag(neg2_q, mdu_res[ProdW-1:FracW]);
          state_d = StAcc;
        end
      end

      StAcc: begin
        acc_d   = sat_add(acc_q, term_q);
        px_d    = x_q;
        py_d    = y_q;
        state_d = StFinal;
      end

      // On end of sweep, scale the sum
      StFinal: begin
        if (eos_q) begin
          opa_d       = {2'd0, mag64(acc_q)};
          opb_d       = {1'b0, scale_q};
          req_d.start = 1'b1;
          req_d.op    = MduMul;
          state_d     = StScale;
        end else begin
          state_d = StIdle;
        end
      end

      StScale: begin
        if (mdu_done) begin
          term_d  = sat_mag(acc_q[63], mdu_res[ProdW-1:FracW]);
          state_d = StEmit;
        end
      end

      // Offer the result word once the register is free, then clear the sweep
      StEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          area_d      = term_q;
          found_d     = armed_q;
          out_valid_d = 1'b1;
          armed_d     = 1'b0;
          limit_d     = 1'b0;
          px_d        = '0;
          py_d        = '0;
          acc_d       = '0;
          state_d     = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      seg_q       <= SegPlain;
      start_x_q   <= '0;
      upper_q     <= '0;
      scale_q     <= 32'd65536;
      armed_q     <= 1'b0;
      limit_q     <= 1'b0;
      px_q        <= '0;
      py_q        <= '0;
      acc_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      eos_q       <= 1'b0;
      neg1_q      <= 1'b0;
      neg2_q      <= 1'b0;
      r_q         <= '0;
      term_q      <= '0;
      req_q       <= '{start: 1'b0, op: MduMul};
      opa_q       <= '0;
      opb_q       <= '0;
      out_valid_q <= 1'b0;
      area_q      <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      seg_q       <= seg_d;
      start_x_q   <= start_x_d;
      upper_q     <= upper_d;
      scale_q     <= scale_d;
      armed_q     <= armed_d;
      limit_q     <= limit_d;
      px_q        <= px_d;
      py_q        <= py_d;
      acc_q       <= acc_d;
      x_q         <= x_d;
      y_q         <= y_d;
      eos_q       <= eos_d;
      neg1_q      <= neg1_d;
      neg2_q      <= neg2_d;
      r_q         <= r_d;
      term_q      <= term_d;
      req_q       <= req_d;
      opa_q       <= opa_d;
      opb_q       <= opb_d;
      out_valid_q <= out_valid_d;
      area_q      <= area_d;
      found_q     <= found_d;
    end
  end

  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = out_valid_q;
  assign area_o        = area_q;
  assign start_found_o = found_q;

endmodule

### src/pati_checker.sv
// Port-level checks for the positive-area trapezoid integrator, bound to the top level.
// Depends only on the top level's ports.
module pati_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [63:0] area_o,
  input logic               start_found_o
);

  // One word in work at a time: input stalls right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a word is in work");

  // A result word never appears in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o))
    else $error("result word without work time");

  // No start seen means no area
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !start_found_o) |-> (area_o == 64'sd0))
    else $error("nonzero area without start");

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(area_o) && $stable(start_found_o)))
    else $error("stalled result word changed");

endmodule

bind positive_area_trapezoid_integrator_core pati_checker u_pati_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .area_o        (area_o),
  .start_found_o (start_found_o)
);

### bench/pati_area_check.sv
// Scoreboard for the positive-area trapezoid integrator: watches the register port
// and both word channels, works out each sweep's area and compares result words.
// Depends on pati_pkg for the register indexes.
module pati_area_check import pati_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] x_sample_i,
  input  logic signed [31:0] y_sample_i,
  input  logic               end_of_sweep_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [63:0] area_i,
  input  logic               start_found_i,
  output int unsigned        fails_o,
  output int unsigned        waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [127:0] wide_t;

  typedef struct packed {
    logic signed [63:0] area;
    logic               found;
  } area_word_t;

  localparam longint SatHigh = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SatLow  = 64'sh8000_0000_0000_0000;

  // Register copies and sweep state
  longint      start_x_q;
  longint      upper_q;
  longint      scale_q;
  bit          armed;
  bit          have_prev;
  bit          limit_hit;
  longint      prev_x;
  longint      prev_y;
  longint      area_sum;
  area_word_t  pending_areas[$];
  area_word_t  head;
  int unsigned fault_count;

  function automatic logic [63:0] mag64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Give a signed value for a magnitude, clamped to the 64-bit range
  function automatic longint clamp_mag(bit neg, wide_t m);
    if (neg) begin
      return (m > (wide_t'(1) << 63)) ? SatLow : -longint'(m[63:0]);
    end
    return (m > ((wide_t'(1) << 63) - 1)) ? SatHigh : longint'(m[63:0]);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      return a[63] ? SatLow : SatHigh;
    end
    return s;
  endfunction

  // (a*b) >> 16 on magnitudes, so the shift truncates toward zero
  function automatic longint q16_product(longint a, longint b);
    wide_t p;
    p = wide_t'(mag64(a)) * wide_t'(mag64(b));
    return clamp_mag((a < 0) != (b < 0), p >> 16);
  endfunction

  // (a*b)/d, truncated toward zero; a zero divisor gives zero
  function automatic longint scaled_quotient(longint a, longint b, longint d);
    wide_t p;
    wide_t dm;
    bit    neg;
    if (d == 0) begin
      return 0;
    end
    neg = ((a < 0) != (b < 0)) != (d < 0);
    p   = wide_t'(mag64(a)) * wide_t'(mag64(b));
    dm  = wide_t'(mag64(d));
    if ((p >> 64) >= dm) begin
      return neg ? SatLow : SatHigh;
    end
    return clamp_mag(neg, p / dm);
  endfunction

  // Doubled area that one segment contributes
  function automatic longint segment_area(longint x0, longint y0, longint x1, longint y1);
    longint dx;
    longint u;
    longint r;
    dx = x1 - x0;
    if (x1 >= upper_q) begin
      if (dx == 0) begin
        return 0;
      end
      u = upper_q - x0;
      r = scaled_quotient(y1 - y0, u, dx);
      return q16_product(u, sat_sum(2 * y0, r));
    end
    if (y0 <= 0 && y1 <= 0) begin
      return 0;
    end
    if (y0 < 0) begin
      return q16_product(dx, scaled_quotient(y1, y1, y1 - y0));
    end
    if (y1 < 0) begin
      return q16_product(dx, scaled_quotient(y0, y0, y0 - y1));
    end
    return q16_product(dx, y0 + y1);
  endfunction

  task automatic clear_sweep();
    armed     = 1'b0;
    have_prev = 1'b0;
    limit_hit = 1'b0;
    prev_x    = 0;
    prev_y    = 0;
    area_sum  = 0;
  endtask

  // Advance the sweep by one sample; queue the area word on end of sweep
  task automatic take_sample(longint x, longint y, bit eos);
    area_word_t w;
    if (!armed) begin
      if (x == start_x_q) begin
        armed     = 1'b1;
        have_prev = 1'b1;
        prev_x    = x;
        prev_y    = y;
      end
    end else if (!limit_hit && have_prev) begin
      area_sum = sat_sum(area_sum, segment_area(prev_x, prev_y, x, y));
      if (x >= upper_q) begin
        limit_hit = 1'b1;
      end
      prev_x = x;
      prev_y = y;
    end
    if (eos) begin
      w.area  = q16_product(area_sum, scale_q);
      w.found = armed;
      pending_areas = {pending_areas, w};
      clear_sweep();
    end
  endtask

  // Track register writes, accepted samples and accepted result words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_sweep();
      start_x_q   = 0;
      upper_q     = 0;
      scale_q     = 65536;
      fault_count = 0;
      pending_areas.delete();
      waiting_o <= 0;
      fails_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStartX:     start_x_q = longint'($signed(cfg_data_i));
          CfgUpperLimit: upper_q   = longint'($signed(cfg_data_i));
          CfgScale:      scale_q   = longint'(cfg_data_i);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        take_sample(longint'(x_sample_i), longint'(y_sample_i), end_of_sweep_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_areas.size() == 0) begin
          fault_count++;
          $error("result word with none pending: area %0d, start_found %0d",
                 area_i, start_found_i);
        end else begin
          head = pending_areas.pop_front();
          if (area_i !== head.area) begin
            fault_count++;
            $error("area: expected %0d, got %0d", head.area, area_i);
          end
          if (start_found_i !== head.found) begin
            fault_count++;
            $error("start_found: expected %0d, got %0d", head.found, start_found_i);
          end
        end
      end
      waiting_o <= pending_areas.size();
      fails_o   <= fault_count;
    end
  end

endmodule

### bench/tb_top.sv
// Top of the integrator bench: clock, reset, register writes, sample words and
// result back-pressure. Depends on pati_pkg, the core and pati_area_check.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pati_pkg::*;

  localparam int unsigned CycleLimit  = 1_200_000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned HoldCycles  = 1500;
  localparam int unsigned RoundWords  = 105;
  localparam logic [31:0] QMin        = 32'h8000_0000;
  localparam logic [31:0] QMax        = 32'h7FFF_FFFF;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               cfg_we       = 1'b0;
  logic [1:0]         cfg_idx      = CfgStartX;
  logic [31:0]        cfg_data     = '0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic signed [31:0] x_sample     = '0;
  logic signed [31:0] y_sample     = '0;
  logic               end_of_sweep = 1'b0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic signed [63:0] area;
  logic               start_found;
  int unsigned        fails;
  int unsigned        waiting;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned words_sent    = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;

  positive_area_trapezoid_integrator_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .x_sample_i     (x_sample),
    .y_sample_i     (y_sample),
    .end_of_sweep_i (end_of_sweep),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .area_o         (area),
    .start_found_o  (start_found)
  );

  pati_area_check area_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .x_sample_i     (x_sample),
    .y_sample_i     (y_sample),
    .end_of_sweep_i (end_of_sweep),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .area_i         (area),
    .start_found_i  (start_found),
    .fails_o        (fails),
    .waiting_o      (waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall result words at random, or hold off for a long stretch on request
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Abandon a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] q16(int v);
    return 32'(v * 65536);
  endfunction

  // Ordinate mix: full range, zero, small and medium of either sign
  function automatic logic [31:0] sample_level();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'd0;
      2: return 32'($urandom_range(0, 32'h5_0000));
      3: return -32'($urandom_range(1, 32'h5_0000));
      default: begin
        if ($urandom_range(0, 1) != 0) begin
          return 32'($urandom_range(0, 32'h7F_FFFF));
        end
        return -32'($urandom_range(0, 32'h7F_FFFF));
      end
    endcase
  endfunction

  // Mostly forward steps, now and then backward or zero-width
  function automatic logic [31:0] next_step(longint max_step);
    case ($urandom_range(0, 9))
      0: return -32'($urandom_range(0, 32'h2_0000));
      1: return 32'd0;
      default: return 32'($urandom_range(1, 32'(max_step)));
    endcase
  endfunction

  // Offer one sample word, with a random gap first; valid stays high on return
  task automatic send_word(input logic [31:0] x, input logic [31:0] y, input logic eos);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    x_sample     <= x;
    y_sample     <= y;
    end_of_sweep <= eos;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Drop valid, wait for every area word, then let the last word in work finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] sx, input logic [31:0] ul,
                            input logic [31:0] sc);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgStartX;
    cfg_data <= sx;
    @(posedge clk);
    cfg_idx  <= CfgUpperLimit;
    cfg_data <= ul;
    @(posedge clk);
    cfg_idx  <= CfgScale;
    cfg_data <= sc;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // One sweep: up to two samples before the start, the start, then segments toward and past the
  // limit; a broken sweep may miss the start and ends early
  task automatic send_sweep(input logic [31:0] sx, input logic [31:0] ul, input bit broken);
    longint      span;
    longint      max_step;
    logic [31:0] x;
    int          cut;
    int          extra;
    bit          past;
    bit          done;
    span     = longint'($signed(ul)) - longint'($signed(sx));
    max_step = (span > 0) ? span / 4 + 1 : 64'h2_0000;
    repeat ($urandom_range(0, 2)) begin
      send_word(sx - 32'($urandom_range(1, 32'h3_0000)), sample_level(), 1'b0);
    end
    x     = (broken && $urandom_range(0, 1) != 0) ? sx + 32'd1 : sx;
    cut   = broken ? $urandom_range(1, 3) : 24;
    extra = $urandom_range(0, 2);
    past  = 1'b0;
    send_word(x, sample_level(), 1'b0);
    for (int i = 1; i <= cut; i++) begin
      x = x + next_step(max_step);
      if ($signed(x) >= $signed(ul)) begin
        past = 1'b1;
      end
      done = (i == cut) || (past && extra == 0);
      send_word(x, sample_level(), done);
      if (past) begin
        extra--;
      end
      if (done) begin
        break;
      end
    end
  endtask

  initial begin
    logic [31:0] sx;
    logic [31:0] ul;
    logic [31:0] sc;
    int unsigned round_base;
    int unsigned pick;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 9;
    recv_idle_pct = 73;

    // Start at 1.0, limit at 10.0, unit scale: every segment shape in one sweep
    set_config(q16(1), q16(10), 32'h0001_0000);
    send_word(q16(5), q16(7), 1'b1);       // end of sweep without start
    send_word(q16(1), q16(2), 1'b0);       // start
    send_word(q16(2), q16(3), 1'b0);       // both ends positive
    send_word(q16(3), q16(-1), 1'b0);      // falls through zero
    send_word(q16(4), q16(-2), 1'b0);      // both ends negative
    send_word(q16(5), q16(4), 1'b0);       // rises through zero
    send_word(q16(1), q16(5), 1'b0);       // start value again, x going back
    send_word(q16(6), 32'd0, 1'b0);
    send_word(q16(6), q16(3), 1'b0);       // zero width below the limit
    send_word(q16(12), q16(1), 1'b0);      // crosses the limit
    send_word(q16(13), q16(9), 1'b0);      // ignored after the limit
    send_word(q16(14), q16(-9), 1'b1);
    drain();

    // Zero-width segment at the limit, full-range scale
    set_config(QMin, QMin, 32'hFFFF_FFFF);
    send_word(QMin, 32'hFFFF_FFFF, 1'b0);
    send_word(QMin, QMax, 1'b0);
    send_word(32'd0, q16(5), 1'b1);
    drain();

    // Full-range span and ordinates: saturate the scaled area
    set_config(QMin, QMax, 32'hFFFF_FFFF);
    send_word(QMin, QMax, 1'b0);
    send_word(32'h7FFF_FFFE, QMax, 1'b0);
    send_word(QMax, QMin, 1'b1);
    drain();

    // Large backward step gives a negative sum
    set_config(32'd0, QMax, 32'h0002_0000);
    send_word(32'd0, QMax, 1'b0);
    send_word(QMin, QMax, 1'b0);
    send_word(32'd0, 32'd0, 1'b1);
    drain();

    // Limit below the start, zero scale
    set_config(32'd0, q16(-3), 32'd0);
    send_word(32'd0, 32'd1, 1'b0);
    send_word(32'd1, 32'd1, 1'b1);
    drain();

    // Random sweeps under changing registers and idling
    for (int r = 0; r < 9; r++) begin
      case (r / 3)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sx = ($urandom_range(0, 1) != 0) ? $urandom()
                                        : 32'($urandom_range(0, 32'h10_0000)) - 32'h8_0000;
      ul = ($urandom_range(0, 5) == 0) ? $urandom()
                                        : sx + 32'($urandom_range(32'h1_0000, 32'h80_0000));
      case ($urandom_range(0, 2))
        0:       sc = $urandom();
        1:       sc = 32'h0001_0000;
        default: sc = 32'($urandom_range(0, 32'h3_0000));
      endcase
      set_config(sx, ul, sc);
      // Back up the result side while words keep coming
      if (r == 6) begin
        hold_requests++;
      end
      round_base = words_sent;
      while (words_sent - round_base < RoundWords) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          send_sweep(sx, ul, 1'b0);
        end else if (pick < 17) begin
          send_sweep(sx, ul, 1'b1);
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_word($urandom(), $urandom(), $urandom_range(0, 7) == 0);
          end
        end
      end
      drain();
    end

    if (fails == 0 && waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
